@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL; only i64g_step includes them.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds in the same cycle as its condition.
`define ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// The property holds in the cycle after its condition.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ hdl/i64g_pkg.sv @@
package i64g_pkg;

  // Table geometry and word width.
  localparam int TABLE_DEPTH = 256;
  localparam int HALF_DEPTH  = TABLE_DEPTH / 2;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int WORD_W      = 64;

  // Bit offsets of the indirect table indexes taken from x and y.
  localparam int X_SHIFT = 3;
  localparam int Y_SHIFT = 11;

  // Shift amounts of the four mixing phases.
  localparam int MIX_SH0 = 21;
  localparam int MIX_SH1 = 5;
  localparam int MIX_SH2 = 12;
  localparam int MIX_SH3 = 33;

  // Function codes carried in tuser.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_GEN  = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [AW-1:0]     addr_t;

  // Sequencer of one generate step: each state issues at most one table read.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_HALF,
    ST_RD_XI,
    ST_RD_YI,
    ST_DONE
  } step_state_t;

  // Finished result handed from the step engine to the output stage.
  typedef struct packed {
    logic  valid;
    word_t word;
    logic  last;
  } result_t;

  // Accumulator mixing, chosen by the low two bits of the position.
  function automatic word_t mix_acc(input word_t a, input logic [1:0] phase);
    word_t m;
    case (phase)
      2'd0:    m = ~(a ^ (a << MIX_SH0));
      2'd1:    m = a ^ (a >> MIX_SH1);
      2'd2:    m = a ^ (a << MIX_SH2);
      default: m = a ^ (a >> MIX_SH3);
    endcase
    return m;
  endfunction

endpackage

@@ hdl/isaac64_generator_round_unit.sv @@
// Channel | Signals                          | Contents
// in      | in_tvalid, in_tready, in_tdata,  | tdata: word_index, seed_word;
//         | in_tuser                         | tuser: func
// out     | out_tvalid, out_tready,          | tdata: random_word;
//         | out_tdata, out_tlast             | tlast: last_of_round
//
// A generate beat makes four table reads, one after another through the single read port.
// A new beat is taken in the last cycle of the previous step, so steps can run back to back.
// A load beat is accepted only between steps.
// Reset clears the sequencer and accumulators; the table is not cleared and must be loaded.
// A finished word sits in the output register; while it has not been taken, the step
// that finishes next waits in its last cycle and no new beat is accepted.
module isaac64_generator_round_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [7:0] word_index, [71:8] seed_word
  input  logic [0:0]  in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] random_word
  output logic        out_tlast
);

  i64g_pkg::result_t res;
  logic              out_free;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [63:0]       out_tdata_r;
  logic              out_tlast_r;

  assign out_free = !out_tvalid_r || out_tready;

  i64g_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .func       (in_tuser[0]),
    .word_index (in_tdata[7:0]),
    .seed_word  (in_tdata[71:8]),
    .out_free   (out_free),
    .in_ready   (in_tready),
    .res        (res)
  );

  // Output register valid: set by a new result, cleared when the beat is taken.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res.valid) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_tdata_r <= res.word;
      out_tlast_r <= res.last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

@@ hdl/i64g_ram.sv @@
module i64g_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port; read data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/i64g_step.sv @@
`include "assert_macros.svh"

module i64g_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              func,
  input  logic [7:0]        word_index,
  input  logic [63:0]       seed_word,
  input  logic              out_free,
  output logic              in_ready,
  output i64g_pkg::result_t res
);

  localparam int AW = i64g_pkg::AW;

  i64g_pkg::step_state_t state_r, state_nxt;

  logic [AW-1:0]       pos_r, pos_nxt;
  i64g_pkg::word_t     a_r, a_nxt;
  i64g_pkg::word_t     b_r, b_nxt;
  i64g_pkg::word_t     cnt_r, cnt_nxt;
  i64g_pkg::word_t     x_r, x_nxt;
  i64g_pkg::word_t     y_r, y_nxt;
  logic                fwd_r, fwd_nxt;

  logic                accept, gen_acc, load_acc;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  i64g_pkg::word_t     mem_wdata, mem_rdata;
  i64g_pkg::word_t     y_comb, done_word;

  // Table storage, one read and one write per cycle.
  i64g_ram #(
    .DEPTH (i64g_pkg::TABLE_DEPTH),
    .WIDTH (i64g_pkg::WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Handshake decode.
  assign in_ready = (state_r == i64g_pkg::ST_IDLE) ||
                    ((state_r == i64g_pkg::ST_DONE) && out_free);
  assign accept   = in_valid && in_ready;
  assign gen_acc  = accept && (func == i64g_pkg::FUNC_GEN);
  assign load_acc = accept && (func == i64g_pkg::FUNC_LOAD);

  // New table entry and the result word, with forwarding when y indexes its own entry.
  assign y_comb    = a_r + b_r + mem_rdata;
  assign done_word = x_r + (fwd_r ? y_r : mem_rdata);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i64g_pkg::ST_IDLE: begin
        if (gen_acc) state_nxt = i64g_pkg::ST_RD_HALF;
      end
      i64g_pkg::ST_RD_HALF: state_nxt = i64g_pkg::ST_RD_XI;
      i64g_pkg::ST_RD_XI:   state_nxt = i64g_pkg::ST_RD_YI;
      i64g_pkg::ST_RD_YI:   state_nxt = i64g_pkg::ST_DONE;
      i64g_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = gen_acc ? i64g_pkg::ST_RD_HALF : i64g_pkg::ST_IDLE;
        end
      end
      default: state_nxt = i64g_pkg::ST_IDLE;
    endcase
  end

  // Memory port control and the result beat.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = pos_r;
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = y_comb;
    res.valid = 1'b0;
    res.word  = done_word;
    res.last  = (pos_r == AW'(i64g_pkg::TABLE_DEPTH - 1));
    case (state_r)
      i64g_pkg::ST_IDLE: begin
        mem_re = gen_acc;
      end
      i64g_pkg::ST_RD_HALF: begin
        mem_re    = 1'b1;
        mem_raddr = pos_r + AW'(i64g_pkg::HALF_DEPTH);
      end
      i64g_pkg::ST_RD_XI: begin
        mem_re    = 1'b1;
        mem_raddr = x_r[i64g_pkg::X_SHIFT +: AW];
      end
      i64g_pkg::ST_RD_YI: begin
        mem_re    = 1'b1;
        mem_raddr = y_comb[i64g_pkg::Y_SHIFT +: AW];
        mem_we    = 1'b1;
      end
      i64g_pkg::ST_DONE: begin
        res.valid = out_free;
        mem_re    = gen_acc;
        mem_raddr = pos_r + AW'(1);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
    // A load beat writes its seed word; it is only taken when no step is writing.
    if (load_acc) begin
      mem_we    = 1'b1;
      mem_waddr = word_index[AW-1:0];
      mem_wdata = seed_word;
    end
  end

  // Accumulator and position updates.
  always_comb begin
    pos_nxt = pos_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    cnt_nxt = cnt_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    fwd_nxt = fwd_r;
    case (state_r)
      i64g_pkg::ST_RD_HALF: begin
        // The first step of a round bumps the counter here and adds it into b next.
        x_nxt = mem_rdata;
        if (pos_r == '0) cnt_nxt = cnt_r + 64'd1;
      end
      i64g_pkg::ST_RD_XI: begin
        a_nxt = i64g_pkg::mix_acc(a_r, pos_r[1:0]) + mem_rdata;
        if (pos_r == '0) b_nxt = b_r + cnt_r;
      end
      i64g_pkg::ST_RD_YI: begin
        y_nxt   = y_comb;
        fwd_nxt = (y_comb[i64g_pkg::Y_SHIFT +: AW] == pos_r);
      end
      i64g_pkg::ST_DONE: begin
        if (out_free) begin
          b_nxt   = done_word;
          pos_nxt = pos_r + AW'(1);
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
    // A load clears the accumulators and restarts the round.
    if (load_acc) begin
      pos_nxt = '0;
      a_nxt   = '0;
      b_nxt   = '0;
      cnt_nxt = '0;
    end
  end

  // Control and accumulator registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i64g_pkg::ST_IDLE;
      pos_r   <= '0;
      a_r     <= '0;
      b_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Per-step scratch values.
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    fwd_r <= fwd_nxt;
  end

  `ASSERT_NOW(a_busy_no_accept,
    (state_r == i64g_pkg::ST_RD_HALF) || (state_r == i64g_pkg::ST_RD_XI) ||
    (state_r == i64g_pkg::ST_RD_YI), !in_ready, "input taken in the middle of a step")
  `ASSERT_NOW(a_write_owner, mem_we,
    (state_r == i64g_pkg::ST_RD_YI) || load_acc, "table written outside its slot")
  `ASSERT_NOW(a_result_slot, res.valid,
    (state_r == i64g_pkg::ST_DONE) && out_free, "result produced outside the final cycle")
  `ASSERT_NEXT(a_gen_starts, gen_acc,
    state_r == i64g_pkg::ST_RD_HALF, "generate beat did not start a step")

endmodule

@@ tb/tb.sv @@
module tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 230;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_PERCENT = 17;

  // One generated word as the block should present it.
  typedef struct packed {
    i64g_pkg::word_t word;
    logic            last;
  } gen_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;

  // Shadow copy of the generator state.
  i64g_pkg::word_t shadow_table [i64g_pkg::TABLE_DEPTH];
  i64g_pkg::word_t shadow_a = '0;
  i64g_pkg::word_t shadow_b = '0;
  i64g_pkg::word_t shadow_rounds = '0;
  i64g_pkg::addr_t shadow_pos = '0;

  gen_result_t expected_words [$];

  logic quiet_mode = 1'b0;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   n_errors = 0;
  int   n_loads = 0;
  int   n_gens = 0;
  int   n_checked = 0;
  int   n_round_ends = 0;

  isaac64_generator_round_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words still outstanding", $realtime,
               expected_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  // A load writes one table entry and restarts the round from scratch.
  function automatic void shadow_load(input i64g_pkg::addr_t idx,
                                      input i64g_pkg::word_t seed);
    shadow_table[idx] = seed;
    shadow_a      = '0;
    shadow_b      = '0;
    shadow_rounds = '0;
    shadow_pos    = '0;
  endfunction

  // One step of the round on the entry at the current position.
  function automatic gen_result_t isaac_next_word();
    gen_result_t     res;
    i64g_pkg::word_t x;
    i64g_pkg::word_t y;
    i64g_pkg::word_t mixed;
    if (shadow_pos == '0) begin
      shadow_rounds = shadow_rounds + 1;
      shadow_b      = shadow_b + shadow_rounds;
    end
    x = shadow_table[shadow_pos];
    case (shadow_pos[1:0])
      2'd0:    mixed = ~(shadow_a ^ (shadow_a << i64g_pkg::MIX_SH0));
      2'd1:    mixed = shadow_a ^ (shadow_a >> i64g_pkg::MIX_SH1);
      2'd2:    mixed = shadow_a ^ (shadow_a << i64g_pkg::MIX_SH2);
      default: mixed = shadow_a ^ (shadow_a >> i64g_pkg::MIX_SH3);
    endcase
    shadow_a = mixed +
               shadow_table[i64g_pkg::addr_t'(shadow_pos + i64g_pkg::HALF_DEPTH)];
    y = shadow_a + shadow_b + shadow_table[x[i64g_pkg::X_SHIFT +: i64g_pkg::AW]];
    shadow_table[shadow_pos] = y;
    shadow_b = x + shadow_table[y[i64g_pkg::Y_SHIFT +: i64g_pkg::AW]];
    res.word = shadow_b;
    res.last = (shadow_pos == i64g_pkg::addr_t'(i64g_pkg::TABLE_DEPTH - 1));
    shadow_pos = shadow_pos + 1'b1;
    return res;
  endfunction

  function automatic logic idle_now();
    return !quiet_mode && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  function automatic i64g_pkg::word_t pick_seed();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one beat and wait until it is taken. in_tvalid stays high on return,
  // so the caller must send the next beat or lower it before letting time pass.
  task automatic send_beat(input logic fn, input i64g_pkg::addr_t idx,
                           input i64g_pkg::word_t seed);
    while (idle_now()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {seed, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (fn == i64g_pkg::FUNC_LOAD) begin
      shadow_load(idx, seed);
      n_loads++;
    end else begin
      expected_words.push_back(isaac_next_word());
      n_gens++;
    end
  endtask

  // A generate beat with random contents in the fields it ignores.
  task automatic send_gen();
    send_beat(i64g_pkg::FUNC_GEN, i64g_pkg::addr_t'($urandom), {$urandom, $urandom});
  endtask

  // Receiver: honors a requested hold-off, otherwise stalls at random unless in quiet mode.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= quiet_mode || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Compare every accepted output beat with the oldest prediction.
  always @(posedge clk) begin
    gen_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected output beat, expected none, actual word %h last %b",
                 $realtime, out_tdata, out_tlast);
      end else begin
        want = expected_words.pop_front();
        n_checked++;
        if (out_tdata !== want.word) begin
          n_errors++;
          $display("%0t: random_word mismatch, expected %h, actual %h",
                   $realtime, want.word, out_tdata);
        end
        if (out_tlast !== want.last) begin
          n_errors++;
          $display("%0t: last_of_round mismatch, expected %b, actual %b",
                   $realtime, want.last, out_tlast);
        end
        if (want.last && out_tlast) n_round_ends++;
      end
    end
  end

  // Write every table entry once, in shuffled order, so no read hits an unwritten entry.
  task automatic test_table_fill();
    i64g_pkg::addr_t order [i64g_pkg::TABLE_DEPTH];
    i64g_pkg::addr_t tmp;
    int              j;
    for (int k = 0; k < i64g_pkg::TABLE_DEPTH; k++) order[k] = i64g_pkg::addr_t'(k);
    for (int k = i64g_pkg::TABLE_DEPTH - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < i64g_pkg::TABLE_DEPTH; k++) begin
      send_beat(i64g_pkg::FUNC_LOAD, order[k], pick_seed());
    end
  endtask

  // Extreme seeds and indexes, junk in the load fields of generate beats,
  // and a load in the middle of a round.
  task automatic test_directed();
    send_beat(i64g_pkg::FUNC_LOAD, i64g_pkg::addr_t'(0), '0);
    send_beat(i64g_pkg::FUNC_LOAD, i64g_pkg::addr_t'(i64g_pkg::TABLE_DEPTH - 1), '1);
    send_beat(i64g_pkg::FUNC_LOAD, i64g_pkg::addr_t'(i64g_pkg::HALF_DEPTH),
              64'h8000_0000_0000_0001);
    send_beat(i64g_pkg::FUNC_LOAD, i64g_pkg::addr_t'(1), 64'h5555_5555_5555_5555);
    for (int k = 0; k < 6; k++) begin
      if (k[0]) send_beat(i64g_pkg::FUNC_GEN, '1, '1);
      else send_beat(i64g_pkg::FUNC_GEN, '0, '0);
    end
    send_beat(i64g_pkg::FUNC_LOAD, i64g_pkg::addr_t'(7), 64'hAAAA_AAAA_AAAA_AAAA);
    for (int k = 0; k < 4; k++) send_gen();
  endtask

  // A full round and a bit more with no idling: last flag, wrap, second round.
  task automatic test_round_wrap();
    quiet_mode = 1'b1;
    for (int k = 0; k < i64g_pkg::TABLE_DEPTH + 6; k++) send_gen();
    quiet_mode = 1'b0;
  endtask

  // Hold the output off for a long time while beats keep coming.
  task automatic test_backpressure();
    quiet_mode = 1'b1;
    stall_left <= 300;
    for (int k = 0; k < 40; k++) send_gen();
    quiet_mode = 1'b0;
  endtask

  // Runs of generate beats, some of them after one to three loads.
  task automatic test_random();
    int beats;
    int run_len;
    beats = 0;
    while (beats < RANDOM_BEATS) begin
      if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(1, 3)) begin
          send_beat(i64g_pkg::FUNC_LOAD, i64g_pkg::addr_t'($urandom), pick_seed());
          beats++;
        end
      end
      run_len = ($urandom_range(99) < 8) ? $urandom_range(256, 290) : $urandom_range(1, 48);
      if (run_len > RANDOM_BEATS - beats) run_len = RANDOM_BEATS - beats;
      for (int k = 0; k < run_len; k++) begin
        send_gen();
        beats++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_fill();
    test_directed();
    test_round_wrap();
    test_backpressure();
    test_random();

    // Stop offering and let the last words come out.
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d load beats and %0d generate beats; %0d words checked.",
             n_loads, n_gens, n_checked);
    $display("Completed rounds seen: %0d; mismatches: %0d.", n_round_ends, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/i64g_pkg.sv
hdl/i64g_ram.sv
hdl/i64g_step.sv
hdl/isaac64_generator_round_unit.sv
tb/tb.sv
